// ----- src/rwrl_pkg.sv -----
`timescale 1ns / 1ps

package rwrl_pkg;

   localparam int TIME_W      = 64;
   localparam int LIMIT_W     = 4;
   localparam int COUNT_OUT_W = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;

   typedef logic [TIME_W-1:0]      time_type;
   typedef logic [LIMIT_W-1:0]     limit_type;
   typedef logic [COUNT_OUT_W-1:0] count_out_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [CSR_ADDR_W-1:0]  csr_addr_type;

   localparam logic OP_ARM   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [1:0] REG_MAX_RESTARTS      = 2'd0;
   localparam logic [1:0] REG_WINDOW_LENGTH     = 2'd1;
   localparam logic [1:0] REG_RESTARTS_DISABLED = 2'd2;

endpackage

// ----- src/rwrl_req_if.sv -----
`timescale 1ns / 1ps

interface rwrl_req_if
   import rwrl_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     opcode;
   time_type now_time;
   logic     in_crash_loop;

   modport source (output valid, output opcode, output now_time, output in_crash_loop,
                   input ready);
   modport sink (input valid, input opcode, input now_time, input in_crash_loop,
                 output ready);
endinterface

// ----- src/rwrl_rsp_if.sv -----
`timescale 1ns / 1ps

interface rwrl_rsp_if
   import rwrl_pkg::*;
();
   logic          valid;
   logic          ready;
   logic          granted;
   count_out_type window_count;

   modport source (output valid, output granted, output window_count, input ready);
   modport sink (input valid, input granted, input window_count, output ready);
endinterface

// ----- src/rwrl_ram.sv -----
`timescale 1ns / 1ps

module rwrl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/restart_window_rate_limiter_unit.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// req       in         valid / ready      opcode, now_time, in_crash_loop
// rsp       out        valid / ready      granted, window_count
// csr       in         apb write / read   max_restarts, window_length, restarts_disabled
//
// one item at a time: after it is taken, a drop scan may remove expired timestamps from
// the ring until it meets a younger entry or empties it, and then the item is decided
// the scan reads the timestamp ring one entry per cycle through its single read port
// reset is synchronous and clears head, count, registers and handshakes; ring data is
// never read before it is written, so the ring needs no clearing pass
// a stalled rsp holds the result; the next item is taken meanwhile and waits to finish

module restart_window_rate_limiter_unit
   import rwrl_pkg::*;
#(
   parameter int RING_DEPTH = 8
) (
   input  logic            clock,
   input  logic            reset,
   rwrl_req_if.sink        req,
   rwrl_rsp_if.source      rsp,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  csr_addr_type    csr_paddr,
   input  csr_data_type    csr_pwdata,
   output csr_data_type    csr_prdata,
   output logic            csr_pready
);

   localparam int HW = RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int LW = CW > LIMIT_W ? CW : LIMIT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PRUNE  = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [HW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   limit_type     max_restarts_ff;
   time_type      window_length_ff;
   logic          restarts_disabled_ff;

   logic          op_ff;
   time_type      now_ff;
   logic          crash_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_granted_ff;
   count_out_type rsp_count_ff;

   logic [LW-1:0] limit_wide;
   logic [CW-1:0] limit;
   logic [HW-1:0] head_inc;
   logic [CW:0]   wr_sum;
   logic [HW-1:0] wr_addr;
   logic [HW-1:0] rd_addr;
   time_type      rd_data;
   logic [TIME_W:0] diff;
   logic          keep_oldest;
   logic          out_free;
   logic          req_fire;
   logic          prune_start;
   logic          arm_ok;
   logic          grant;
   logic          decide_fire;
   logic          csr_write;
   logic [1:0]    csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_index)
         REG_MAX_RESTARTS:      csr_prdata = CSR_DATA_W'(max_restarts_ff);
         REG_WINDOW_LENGTH:     csr_prdata = window_length_ff;
         REG_RESTARTS_DISABLED: csr_prdata = CSR_DATA_W'(restarts_disabled_ff);
         default:               csr_prdata = '0;
      endcase
   end

   assign limit_wide = (LW'(max_restarts_ff) > LW'(RING_DEPTH)) ? LW'(RING_DEPTH)
                                                                : LW'(max_restarts_ff);
   assign limit      = limit_wide[CW-1:0];

   assign head_inc = (head_ff == HW'(RING_DEPTH - 1)) ? '0 : head_ff + HW'(1);
   assign wr_sum   = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign wr_addr  = (wr_sum >= (CW+1)'(RING_DEPTH)) ? HW'(wr_sum - (CW+1)'(RING_DEPTH))
                                                    : HW'(wr_sum);
   assign rd_addr  = (state_ff == ST_PRUNE) ? head_inc : head_ff;

   assign diff        = {1'b0, now_ff} - {1'b0, rd_data};
   assign keep_oldest = diff[TIME_W] || (diff[TIME_W-1:0] < window_length_ff);

   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign req.ready   = (state_ff == ST_IDLE);
   assign req_fire    = req.valid && req.ready;
   assign prune_start = (limit != '0) && (window_length_ff != '0) && (count_ff != '0)
                        && (((req.opcode == OP_ARM) && !restarts_disabled_ff)
                            || ((req.opcode == OP_CLEAR) && req.in_crash_loop));

   assign arm_ok      = (op_ff == OP_ARM) && !restarts_disabled_ff && (count_ff < limit);
   assign grant       = (op_ff == OP_ARM) ? arm_ok : (!crash_ff || (count_ff < limit));
   assign decide_fire = (state_ff == ST_DECIDE) && out_free;

   rwrl_ram #(
      .WIDTH (TIME_W),
      .DEPTH (RING_DEPTH)
   ) u_time_ring (
      .clock   (clock),
      .wr_en   (decide_fire && arm_ok),
      .wr_addr (wr_addr),
      .wr_data (now_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = prune_start ? ST_PRUNE : ST_DECIDE;
            end
         end
         ST_PRUNE: begin
            if (keep_oldest) begin
               state_in = ST_DECIDE;
            end else begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  head_in  = '0;
                  state_in = ST_DECIDE;
               end else begin
                  head_in = head_inc;
               end
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               if (arm_ok) begin
                  count_in = count_ff + CW'(1);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         head_ff              <= '0;
         count_ff             <= '0;
         rsp_valid_ff         <= 1'b0;
         max_restarts_ff      <= '0;
         window_length_ff     <= '0;
         restarts_disabled_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               REG_MAX_RESTARTS:      max_restarts_ff      <= csr_pwdata[LIMIT_W-1:0];
               REG_WINDOW_LENGTH:     window_length_ff     <= csr_pwdata;
               REG_RESTARTS_DISABLED: restarts_disabled_ff <= csr_pwdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req.opcode;
         now_ff   <= req.now_time;
         crash_ff <= req.in_crash_loop;
      end
      if (decide_fire) begin
         rsp_granted_ff <= grant;
         rsp_count_ff   <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.granted      = rsp_granted_ff;
   assign rsp.window_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) <= RING_DEPTH))
      else $error("ring count above ring depth");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0))
      else $error("empty ring with nonzero head");

   a_prune_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRUNE) |-> (count_ff != '0))
      else $error("drop scan on empty ring");

   a_decide_result: assert property (@(posedge clock) disable iff (reset)
      decide_fire |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished item did not reach rsp");
`endif

endmodule
